@@ sv/suk_pkg.sv @@
package suk_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int KEY_WIDTH_DEF = 32;

    localparam int OPCODE_W = 2;
    localparam int STATUS_W = 3;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_SEARCH = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_DUMP   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_LISTED    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd4;
    localparam logic [STATUS_W-1:0] ST_MISSING   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd6;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd7;

    // Outcome of one signed key comparison.
    typedef struct packed {
        logic lt;
        logic eq;
    } cmp_res_t;

endpackage

@@ sv/sorted_unique_key_table.sv @@
// Channel  | Direction | Ports                                     | Handshake
// request  | in        | s_opcode, s_key                           | s_valid / s_ready
// result   | out       | m_status, m_result_key, m_last            | m_valid / m_ready
//
// One request is worked on at a time; s_ready is high only while the sequencer is idle.
// Insert, remove and search read and compare the stored entries in order; an insert
// or remove then reads and writes each later entry to move it one place. An empty
// table answers remove, search and dump without a scan; a dump reads out each stored key.
// Reset (aresetn low, synchronous) empties the table at once; no clearing pass is needed.
// A stalled result port holds the sequencer at its next result; nothing is dropped.
module sorted_unique_key_table #(
    parameter int CAPACITY  = suk_pkg::CAPACITY_DEF,
    parameter int KEY_WIDTH = suk_pkg::KEY_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [suk_pkg::OPCODE_W-1:0]         s_opcode,
    input  logic signed [KEY_WIDTH-1:0]          s_key,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [suk_pkg::STATUS_W-1:0]         m_status,
    output logic signed [KEY_WIDTH-1:0]          m_result_key,
    output logic                                 m_last
);

    // Address bits reach every entry; the cursor and count also hold CAPACITY itself.
    localparam int ADDR_W = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CNT_CAP = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_SCAN_RD  = 11'b000_0000_0010,
        S_SCAN_CMP = 11'b000_0000_0100,
        S_DECIDE   = 11'b000_0000_1000,
        S_SHIFT_RD = 11'b000_0001_0000,
        S_UP_WR    = 11'b000_0010_0000,
        S_DN_WR    = 11'b000_0100_0000,
        S_PUT      = 11'b000_1000_0000,
        S_RESP     = 11'b001_0000_0000,
        S_DUMP_RD  = 11'b010_0000_0000,
        S_DUMP_OUT = 11'b100_0000_0000
    } state_t;

    state_t                        state_reg, state_next;
    logic [suk_pkg::OPCODE_W-1:0]  op_reg, op_next;
    logic signed [KEY_WIDTH-1:0]   key_reg, key_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic [CNT_W-1:0]              idx_reg, idx_next;
    logic [CNT_W-1:0]              pos_reg, pos_next;
    logic                          hit_reg, hit_next;
    logic [suk_pkg::STATUS_W-1:0]  resp_reg, resp_next;

    logic                          m_valid_reg, m_valid_next;
    logic [suk_pkg::STATUS_W-1:0]  m_status_reg, m_status_next;
    logic signed [KEY_WIDTH-1:0]   m_key_reg, m_key_next;
    logic                          m_last_reg, m_last_next;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic signed [KEY_WIDTH-1:0]   ram_wdata;
    logic signed [KEY_WIDTH-1:0]   ram_rdata;
    suk_pkg::cmp_res_t             cmp_res;
    logic                          out_free;

    // The key store. The read port always follows the cursor, so the entry under the
    // cursor is on ram_rdata in the cycle after the cursor settles.
    suk_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    // The one comparator, reused for every entry of a scan.
    suk_cmp #(
        .KEY_WIDTH (KEY_WIDTH)
    ) u_cmp (
        .stored_key (ram_rdata),
        .probe_key  (key_reg),
        .res        (cmp_res)
    );

    // The output register may be loaded when it is empty or its beat leaves now.
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        cnt_next      = cnt_reg;
        idx_next      = idx_reg;
        pos_next      = pos_reg;
        hit_next      = hit_reg;
        resp_next     = resp_reg;
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_key_next    = m_key_reg;
        m_last_next   = m_last_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg[ADDR_W-1:0];
        ram_wdata     = key_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    op_next  = s_opcode;
                    key_next = s_key;
                    idx_next = '0;
                    if (cnt_reg == '0 && s_opcode != suk_pkg::OP_INSERT) begin
                        // Remove, search and dump of an empty table answer at once.
                        resp_next  = suk_pkg::ST_EMPTY;
                        state_next = S_RESP;
                    end else if (s_opcode == suk_pkg::OP_DUMP) begin
                        state_next = S_DUMP_RD;
                    end else begin
                        state_next = S_SCAN_RD;
                    end
                end
            end

            S_SCAN_RD: begin
                // Reaching the end of the stored entries means the key is absent.
                if (idx_reg == cnt_reg) begin
                    pos_next   = idx_reg;
                    hit_next   = 1'b0;
                    state_next = S_DECIDE;
                end else begin
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP: begin
                if (cmp_res.lt) begin
                    idx_next   = idx_reg + CNT_ONE;
                    state_next = S_SCAN_RD;
                end else begin
                    pos_next   = idx_reg;
                    hit_next   = cmp_res.eq;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE: begin
                state_next = S_RESP;
                case (op_reg)
                    suk_pkg::OP_INSERT: begin
                        if (hit_reg) begin
                            resp_next = suk_pkg::ST_DUPLICATE;
                        end else if (cnt_reg == CNT_CAP) begin
                            resp_next = suk_pkg::ST_FULL;
                        end else if (pos_reg == cnt_reg) begin
                            state_next = S_PUT;
                        end else begin
                            // Move entries up one place, starting at the top.
                            idx_next   = cnt_reg - CNT_ONE;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    suk_pkg::OP_REMOVE: begin
                        if (!hit_reg) begin
                            resp_next = suk_pkg::ST_MISSING;
                        end else if (pos_reg + CNT_ONE == cnt_reg) begin
                            cnt_next  = cnt_reg - CNT_ONE;
                            resp_next = suk_pkg::ST_REMOVED;
                        end else begin
                            // Close the gap by moving later entries down one place.
                            idx_next   = pos_reg + CNT_ONE;
                            state_next = S_SHIFT_RD;
                        end
                    end
                    default: begin
                        resp_next = hit_reg ? suk_pkg::ST_FOUND : suk_pkg::ST_MISSING;
                    end
                endcase
            end

            S_SHIFT_RD: begin
                state_next = (op_reg == suk_pkg::OP_INSERT) ? S_UP_WR : S_DN_WR;
            end

            S_UP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[ADDR_W-1:0] + ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (idx_reg == pos_reg) begin
                    state_next = S_PUT;
                end else begin
                    idx_next   = idx_reg - CNT_ONE;
                    state_next = S_SHIFT_RD;
                end
            end

            S_DN_WR: begin
                ram_we    = 1'b1;
                ram_waddr = idx_reg[ADDR_W-1:0] - ADDR_W'(1);
                ram_wdata = ram_rdata;
                if (idx_reg + CNT_ONE == cnt_reg) begin
                    cnt_next   = cnt_reg - CNT_ONE;
                    resp_next  = suk_pkg::ST_REMOVED;
                    state_next = S_RESP;
                end else begin
                    idx_next   = idx_reg + CNT_ONE;
                    state_next = S_SHIFT_RD;
                end
            end

            S_PUT: begin
                ram_we     = 1'b1;
                cnt_next   = cnt_reg + CNT_ONE;
                resp_next  = suk_pkg::ST_INSERTED;
                state_next = S_RESP;
            end

            S_RESP: begin
                // Every single-beat answer echoes the request key; a removed or found
                // entry equals it.
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = resp_reg;
                    m_key_next    = key_reg;
                    m_last_next   = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_DUMP_RD: begin
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT: begin
                if (out_free) begin
                    m_valid_next  = 1'b1;
                    m_status_next = suk_pkg::ST_LISTED;
                    m_key_next    = ram_rdata;
                    m_last_next   = (idx_reg + CNT_ONE == cnt_reg);
                    if (idx_reg + CNT_ONE == cnt_reg) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = idx_reg + CNT_ONE;
                        state_next = S_DUMP_RD;
                    end
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        idx_reg      <= idx_next;
        pos_reg      <= pos_next;
        hit_reg      <= hit_next;
        resp_reg     <= resp_next;
        m_status_reg <= m_status_next;
        m_key_reg    <= m_key_next;
        m_last_reg   <= m_last_next;
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_result_key = m_key_reg;
    assign m_last       = m_last_reg;

endmodule

@@ sv/suk_ram.sv @@
module suk_ram #(
    parameter int WIDTH = suk_pkg::KEY_WIDTH_DEF,
    parameter int DEPTH = suk_pkg::CAPACITY_DEF
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ sv/suk_cmp.sv @@
module suk_cmp #(
    parameter int KEY_WIDTH = suk_pkg::KEY_WIDTH_DEF
) (
    input  logic signed [KEY_WIDTH-1:0] stored_key,
    input  logic signed [KEY_WIDTH-1:0] probe_key,
    output suk_pkg::cmp_res_t           res
);

    // Two's complement order of the stored entry against the probe.
    assign res.lt = (stored_key < probe_key);
    assign res.eq = (stored_key == probe_key);

endmodule

@@ sv/suk_checker.sv @@
module suk_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [suk_pkg::STATUS_W-1:0]  m_status,
    input logic                          m_last
);

    // A pending result beat is not withdrawn.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat withdrawn before it was taken");

    // An accepted request keeps the block busy for at least the next cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("request accepted while the previous one is still running");

    // Only dump entries may be followed by further beats of the same request.
    a_single_beat_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status != suk_pkg::ST_LISTED |-> m_last)
        else $error("single-beat answer without last");

    // Reset leaves the block idle with no result pending.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> s_ready && !m_valid)
        else $error("block not idle after reset");

endmodule

bind sorted_unique_key_table suk_checker u_suk_checker (.*);

@@ tb/tb_sorted_unique_key_table.sv @@
module tb_sorted_unique_key_table;

    import suk_pkg::*;

    localparam int CAP         = CAPACITY_DEF;
    localparam int KW          = KEY_WIDTH_DEF;
    localparam int ITEM_TARGET = 420;
    localparam int POOL_SIZE   = 24;
    // The worst case per request is a full scan and shift, a send gap, and a
    // full dump of 16 beats, each of which the monitor may stall.
    // The limit leaves a wide margin for the whole run.
    localparam int CYCLE_LIMIT = 600000;
    localparam int TAIL_CYCLES = 100;

    // One request as the sender will present it, with its pacing attached.
    typedef struct {
        logic [OPCODE_W-1:0]  opcode;
        logic signed [KW-1:0] key;
        int                   gap;
        bit                   drain;
    } table_request_t;

    // One beat the result channel should produce.
    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic signed [KW-1:0] rkey;
        logic                 last;
    } table_reply_t;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_NOISE} phase_kind_e;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [OPCODE_W-1:0]  s_opcode = OP_INSERT;
    logic signed [KW-1:0] s_key = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [STATUS_W-1:0]  m_status;
    logic signed [KW-1:0] m_result_key;
    logic                 m_last;

    sorted_unique_key_table #(
        .CAPACITY  (CAP),
        .KEY_WIDTH (KW)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_key        (s_key),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_result_key (m_result_key),
        .m_last       (m_last)
    );

    // Requests waiting to be driven, and result beats predicted but not yet seen.
    table_request_t pending_requests[$];
    table_reply_t   replies_due[$];

    // Shadow copy of the table contents, kept in ascending signed order.
    logic signed [KW-1:0] table_keys [CAP];
    int                   table_fill = 0;

    // Keys drawn for the random part come mostly from this small pool, so that
    // hits, duplicates and a full table all happen often.
    logic signed [KW-1:0] key_pool [POOL_SIZE];

    int error_count  = 0;
    int cycle_count  = 0;
    int idle_so_far  = 0;
    int stall_left   = 0;
    int beats_seen   = 0;
    bit rx_quiet     = 1'b0;

    initial begin
        forever #2 aclk = ~aclk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    function automatic void push_reply(input logic [STATUS_W-1:0] status,
                                       input logic signed [KW-1:0] rkey,
                                       input logic last);
        table_reply_t r;
        r.status = status;
        r.rkey   = rkey;
        r.last   = last;
        replies_due.push_back(r);
    endfunction

    // Applies one accepted request to the shadow table and queues every result
    // beat it should cause. Keys are compared as signed values throughout.
    function automatic void apply_request(input logic [OPCODE_W-1:0] op,
                                          input logic signed [KW-1:0] key);
        int pos;
        bit hit;
        if (op == OP_DUMP) begin
            // An empty dump still answers once, echoing the request key.
            if (table_fill == 0) begin
                push_reply(ST_EMPTY, key, 1'b1);
            end else begin
                for (int i = 0; i < table_fill; i++) begin
                    push_reply(ST_LISTED, table_keys[i], (i == table_fill - 1));
                end
            end
        end else if (op != OP_INSERT && table_fill == 0) begin
            push_reply(ST_EMPTY, key, 1'b1);
        end else begin
            pos = 0;
            while (pos < table_fill && table_keys[pos] < key) begin
                pos++;
            end
            hit = (pos < table_fill) && (table_keys[pos] == key);
            case (op)
                OP_INSERT: begin
                    // A duplicate is reported even when the table is full.
                    if (hit) begin
                        push_reply(ST_DUPLICATE, key, 1'b1);
                    end else if (table_fill >= CAP) begin
                        push_reply(ST_FULL, key, 1'b1);
                    end else begin
                        for (int i = table_fill; i > pos; i--) begin
                            table_keys[i] = table_keys[i-1];
                        end
                        table_keys[pos] = key;
                        table_fill++;
                        push_reply(ST_INSERTED, key, 1'b1);
                    end
                end
                OP_REMOVE: begin
                    if (!hit) begin
                        push_reply(ST_MISSING, key, 1'b1);
                    end else begin
                        push_reply(ST_REMOVED, table_keys[pos], 1'b1);
                        for (int i = pos; i + 1 < table_fill; i++) begin
                            table_keys[i] = table_keys[i+1];
                        end
                        table_fill--;
                    end
                end
                default: begin
                    if (!hit) begin
                        push_reply(ST_MISSING, key, 1'b1);
                    end else begin
                        push_reply(ST_FOUND, table_keys[pos], 1'b1);
                    end
                end
            endcase
        end
    endfunction

    function automatic void queue_request(input logic [OPCODE_W-1:0] op,
                                          input logic signed [KW-1:0] key,
                                          input int gap, input bit drain);
        table_request_t t;
        t.opcode = op;
        t.key    = key;
        t.gap    = gap;
        t.drain  = drain;
        pending_requests.push_back(t);
    endfunction

    function automatic logic signed [KW-1:0] draw_key();
        int pick;
        logic signed [KW-1:0] k;
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end else if (pick <= 8) begin
            k = $urandom;
        end else begin
            case ($urandom_range(0, 3))
                0:       k = {1'b0, {(KW-1){1'b1}}};
                1:       k = {1'b1, {(KW-1){1'b0}}};
                2:       k = '0;
                default: k = '1;
            endcase
        end
        return k;
    endfunction

    // Picks the opcode of one random request according to the phase it belongs to.
    // Fill phases push the table to capacity, drain phases empty it again, and
    // mixed and noise phases spread all four operations around.
    function automatic logic [OPCODE_W-1:0] draw_opcode(input phase_kind_e kind);
        int r;
        logic [OPCODE_W-1:0] op;
        r = $urandom_range(0, 99);
        case (kind)
            PH_FILL:  op = (r < 80) ? OP_INSERT : (r < 90) ? OP_DUMP : OP_SEARCH;
            PH_DRAIN: op = (r < 70) ? OP_REMOVE : (r < 85) ? OP_SEARCH : OP_DUMP;
            PH_MIXED: op = (r < 35) ? OP_INSERT : (r < 60) ? OP_REMOVE :
                           (r < 85) ? OP_SEARCH : OP_DUMP;
            default:  op = $urandom_range(0, 3);
        endcase
        return op;
    endfunction

    // Driver: presents the head of the pending queue once its idle gap has run
    // out. A request marked for draining is held back until every predicted beat
    // has come out, which leaves the block completely idle in front of it. The
    // shadow table is updated at the very edge where the request beat is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid     <= 1'b0;
            s_opcode    <= OP_INSERT;
            s_key       <= '0;
            idle_so_far = 0;
        end else begin
            if (s_valid && s_ready) begin
                apply_request(s_opcode, s_key);
            end
            if (!s_valid || s_ready) begin
                if (pending_requests.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending_requests[0].drain && replies_due.size() != 0) begin
                    s_valid <= 1'b0;
                end else if (idle_so_far < pending_requests[0].gap) begin
                    idle_so_far++;
                    s_valid <= 1'b0;
                end else begin
                    s_valid     <= 1'b1;
                    s_opcode    <= pending_requests[0].opcode;
                    s_key       <= pending_requests[0].key;
                    idle_so_far = 0;
                    void'(pending_requests.pop_front());
                end
            end
        end
    end

    // Monitor: checks every result beat against the oldest prediction, then
    // decides how long to hold ready low before the next one. Every forty beats
    // it chooses whether the next stretch stalls at all.
    always @(posedge aclk) begin
        table_reply_t want;
        if (!aresetn) begin
            m_ready    <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    flag_error($sformatf("unexpected beat: status %0d key %0d last %0b",
                                         m_status, m_result_key, m_last));
                end else begin
                    want = replies_due.pop_front();
                    if (m_status !== want.status) begin
                        flag_error($sformatf("status %0d, expected %0d (key %0d)",
                                             m_status, want.status, want.rkey));
                    end
                    if (m_result_key !== want.rkey) begin
                        flag_error($sformatf("result_key %0d, expected %0d (status %0d)",
                                             m_result_key, want.rkey, want.status));
                    end
                    if (m_last !== want.last) begin
                        flag_error($sformatf("last %0b, expected %0b (key %0d)",
                                             m_last, want.last, want.rkey));
                    end
                end
                if (beats_seen % 40 == 0) begin
                    rx_quiet = ($urandom_range(0, 2) == 0);
                end
                beats_seen++;
                stall_left = rx_quiet ? 0 : $urandom_range(0, 6);
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_sorted_unique_key_table NOT OK");
            $finish;
        end
    end

    initial begin
        phase_kind_e kind;
        int          phase_len;
        int          phase_index;
        bit          tx_quiet;
        logic signed [KW-1:0] kmax;
        logic signed [KW-1:0] kmin;

        kmax = {1'b0, {(KW-1){1'b1}}};
        kmin = {1'b1, {(KW-1){1'b0}}};

        key_pool[0] = kmax;
        key_pool[1] = kmin;
        key_pool[2] = '0;
        key_pool[3] = '1;
        for (int i = 4; i < 14; i++) begin
            key_pool[i] = $signed($urandom_range(0, 40)) - 20;
        end
        for (int i = 14; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
        end

        // Directed part. It starts with every operation on an empty table, the
        // empty dump echoing its key, and then the first insert into an empty table.
        queue_request(OP_SEARCH, 5, 0, 1'b0);
        queue_request(OP_REMOVE, -7, 0, 1'b0);
        queue_request(OP_DUMP, kmin, 0, 1'b0);
        queue_request(OP_INSERT, 0, 0, 1'b0);
        // The extremes of the key range, placed at both ends of the order.
        queue_request(OP_INSERT, kmax, 0, 1'b0);
        queue_request(OP_INSERT, kmin, 0, 1'b0);
        queue_request(OP_INSERT, -1, 0, 1'b0);
        queue_request(OP_INSERT, 1, 0, 1'b0);
        // Duplicates, hits at both ends, and misses.
        queue_request(OP_INSERT, 0, 0, 1'b0);
        queue_request(OP_INSERT, kmax, 0, 1'b0);
        queue_request(OP_SEARCH, kmin, 0, 1'b0);
        queue_request(OP_SEARCH, kmax, 0, 1'b0);
        queue_request(OP_SEARCH, 2, 0, 1'b0);
        queue_request(OP_REMOVE, 3, 0, 1'b0);
        queue_request(OP_DUMP, 0, 0, 1'b1);
        // Removal at the low end, the high end and in the middle, down to empty.
        queue_request(OP_REMOVE, kmin, 0, 1'b0);
        queue_request(OP_REMOVE, kmax, 0, 1'b0);
        queue_request(OP_REMOVE, 0, 0, 1'b0);
        queue_request(OP_DUMP, 0, 0, 1'b0);
        queue_request(OP_REMOVE, -1, 0, 1'b0);
        queue_request(OP_REMOVE, 1, 0, 1'b0);
        queue_request(OP_DUMP, kmax, 0, 1'b0);
        // Alternating bit patterns so every key bit toggles in both directions.
        queue_request(OP_INSERT, 32'hAAAA_AAAA, 0, 1'b0);
        queue_request(OP_INSERT, 32'h5555_5555, 0, 1'b0);
        queue_request(OP_DUMP, 0, 0, 1'b0);

        // Random part, in phases. The first phase always fills the table so that a
        // full table, a full dump and an insert into a full table are all reached.
        // The first request of each phase waits until the block has gone idle.
        phase_index = 0;
        while (pending_requests.size() < ITEM_TARGET) begin
            if (phase_index == 0) begin
                kind      = PH_FILL;
                phase_len = 45;
            end else begin
                kind      = phase_kind_e'($urandom_range(0, 3));
                phase_len = $urandom_range(15, 40);
            end
            tx_quiet = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < phase_len; i++) begin
                queue_request(draw_opcode(kind),
                              (kind == PH_NOISE) ? $urandom : draw_key(),
                              tx_quiet ? 0 : $urandom_range(0, 6),
                              (i == 0));
            end
            phase_index++;
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_requests.size() != 0 || s_valid || replies_due.size() != 0) begin
            @(posedge aclk);
        end
        // Give the block time to show any beat it should not produce.
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (error_count == 0 && replies_due.size() == 0) begin
            $display("tb_sorted_unique_key_table OK");
        end else begin
            $display("tb_sorted_unique_key_table NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/suk_pkg.sv
sv/suk_ram.sv
sv/suk_cmp.sv
sv/sorted_unique_key_table.sv
sv/suk_checker.sv
tb/tb_sorted_unique_key_table.sv
